[rtl/mexp_pkg.sv]
package mexp_pkg;

	localparam int DEF_WIDTH = 16;

	// Configuration register indexes.
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_EXPONENT = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_MODULUS  = 1'b1;

	// Smallest modulus the block accepts; smaller writes saturate to it.
	localparam int MIN_MODULUS = 2;

endpackage

[rtl/modular_exponentiation.sv]
// The message is first reduced, then the block does one modular multiply per set exponent bit
// and one squaring per exponent bit below the top set one.
// Throughput: one item at a time; the bit-serial modular multiplier sets the pace.
// The result shows for one cycle on done and cannot be stalled.
// Reset clears the sequencer and sets exponent to 0 and modulus to 2.
module modular_exponentiation #(
	parameter int WIDTH = mexp_pkg::DEF_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [WIDTH-1:0]               message,
	output logic                           done,
	output logic [WIDTH-1:0]               power_mod,
	input  logic                           wr_en,
	input  logic [mexp_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [WIDTH-1:0]               wr_data
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RED  = 4'b0010,
		ST_MUL  = 4'b0100,
		ST_SQR  = 4'b1000
	} state_t;

	state_t           state_q;
	state_t           state_d;
	logic [WIDTH-1:0] exponent_q;
	logic [WIDTH-1:0] modulus_q;
	logic [WIDTH-1:0] exp_q;
	logic [WIDTH-1:0] exp_d;
	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] acc_d;
	logic [WIDTH-1:0] sq_q;
	logic [WIDTH-1:0] sq_d;
	logic             go_q;
	logic             go_d;
	logic             done_q;
	logic             finish;
	logic [WIDTH-1:0] result_d;
	logic [WIDTH-1:0] power_mod_q;
	logic [WIDTH-1:0] exp_shr;

	logic             mm_start;
	logic [WIDTH-1:0] mm_a;
	logic [WIDTH-1:0] mm_b;
	logic             mm_done;
	logic [WIDTH-1:0] mm_product;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exponent_q <= '0;
			modulus_q  <= WIDTH'(mexp_pkg::MIN_MODULUS);
		end else if (wr_en) begin
			unique case (wr_index)
				mexp_pkg::REG_EXPONENT: exponent_q <= wr_data;
				mexp_pkg::REG_MODULUS: begin
					if (wr_data < WIDTH'(mexp_pkg::MIN_MODULUS)) begin
						modulus_q <= WIDTH'(mexp_pkg::MIN_MODULUS);
					end else begin
						modulus_q <= wr_data;
					end
				end
				default: ;
			endcase
		end
	end

	assign exp_shr = {1'b0, exp_q[WIDTH-1:1]};

	// The message is first reduced by multiplying it by one. Then each round
	// folds the square into the accumulator on a set bit and squares once more
	// only while exponent bits remain.
	always_comb begin
		state_d  = state_q;
		exp_d    = exp_q;
		acc_d    = acc_q;
		sq_d     = sq_q;
		go_d     = 1'b0;
		finish   = 1'b0;
		result_d = acc_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					exp_d   = exponent_q;
					state_d = ST_RED;
				end
			end
			ST_RED: begin
				if (mm_done) begin
					sq_d  = mm_product;
					acc_d = WIDTH'(1);
					if (exp_q == '0) begin
						finish   = 1'b1;
						result_d = WIDTH'(1);
						state_d  = ST_IDLE;
					end else if (exp_q[0]) begin
						go_d    = 1'b1;
						state_d = ST_MUL;
					end else begin
						exp_d   = exp_shr;
						go_d    = 1'b1;
						state_d = ST_SQR;
					end
				end
			end
			ST_MUL: begin
				if (mm_done) begin
					acc_d = mm_product;
					exp_d = exp_shr;
					if (exp_shr == '0) begin
						finish   = 1'b1;
						result_d = mm_product;
						state_d  = ST_IDLE;
					end else begin
						go_d    = 1'b1;
						state_d = ST_SQR;
					end
				end
			end
			ST_SQR: begin
				if (mm_done) begin
					sq_d = mm_product;
					go_d = 1'b1;
					if (exp_q[0]) begin
						state_d = ST_MUL;
					end else begin
						exp_d   = exp_shr;
						state_d = ST_SQR;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			go_q    <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			go_q    <= go_d;
			done_q  <= finish;
		end
	end

	always_ff @(posedge clk) begin
		exp_q <= exp_d;
		acc_q <= acc_d;
		sq_q  <= sq_d;
		if (finish) begin
			power_mod_q <= result_d;
		end
	end

	assign mm_start = ((state_q == ST_IDLE) && start) || go_q;
	assign mm_a     = (state_q == ST_IDLE) ? message :
	                  (state_q == ST_MUL)  ? acc_q : sq_q;
	assign mm_b     = (state_q == ST_IDLE) ? WIDTH'(1) : sq_q;

	mexp_modmul #(
		.WIDTH(WIDTH)
	) u_modmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm_start),
		.a      (mm_a),
		.b      (mm_b),
		.n      (modulus_q),
		.done   (mm_done),
		.product(mm_product)
	);

	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign power_mod = power_mod_q;

endmodule

[rtl/mexp_modmul.sv]
module mexp_modmul #(
	parameter int WIDTH = mexp_pkg::DEF_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] a,
	input  logic [WIDTH-1:0] b,
	input  logic [WIDTH-1:0] n,
	output logic             done,
	output logic [WIDTH-1:0] product
);

	localparam int CNT_W = $clog2(WIDTH);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WIDTH-1:0] a_q;
	logic [WIDTH-1:0] b_q;
	logic [WIDTH-1:0] r_q;

	logic [WIDTH-1:0] addend;
	logic [WIDTH+1:0] t;
	logic [WIDTH+1:0] n1;
	logic [WIDTH+1:0] n2;
	logic [WIDTH+1:0] t_n1;
	logic [WIDTH+1:0] t_n2;
	logic [WIDTH-1:0] r_d;

	// One bit of a per cycle, most significant first. The running remainder
	// stays below n and b is below n, so 2r + b is below 3n and one of two
	// parallel subtractions brings it back into range.
	always_comb begin
		addend = a_q[WIDTH-1] ? b_q : '0;
		t      = {1'b0, r_q, 1'b0} + {2'b00, addend};
		n1     = {2'b00, n};
		n2     = {1'b0, n, 1'b0};
		t_n1   = t - n1;
		t_n2   = t - n2;
		if (t >= n2) begin
			r_d = t_n2[WIDTH-1:0];
		end else if (t >= n1) begin
			r_d = t_n1[WIDTH-1:0];
		end else begin
			r_d = t[WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(WIDTH - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			r_q <= '0;
		end else if (run_q) begin
			a_q <= {a_q[WIDTH-2:0], 1'b0};
			r_q <= r_d;
		end
	end

	assign done    = done_q;
	assign product = r_q;

endmodule

[rtl/mexp_chk.sv]
module mexp_chk (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// An accepted beat keeps the block busy in the next cycle.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted beat did not make the block busy");

	// A result is shown only once the work is over.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	// Every end of work delivers a result, and no result appears without work.
	a_fell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("work ended without a result");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without preceding work");

endmodule

bind modular_exponentiation mexp_chk u_mexp_chk (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done)
);

[sim/tb_modular_exponentiation.sv]
`timescale 1ns / 1ps
module tb_modular_exponentiation;
	import mexp_pkg::*;

	localparam int W = DEF_WIDTH;
	// Slowest item: message reduction, a multiply on every exponent bit and a squaring
	// between each pair of them.
	localparam int DRAIN_CYCLES = (W + 1) + (2 * W - 1) * (W + 2) + 1;
	localparam int STALL_LIMIT = 8 * DRAIN_CYCLES;
	localparam int PHASES = 22;
	localparam int PHASE_ITEMS = 50;

	class powmod_tracker;
		logic [W-1:0] exponent_val;
		logic [W-1:0] modulus_val;
		logic [W-1:0] expected_powers[$];
		int errors;

		function new();
			exponent_val = '0;
			modulus_val = W'(MIN_MODULUS);
			errors = 0;
		endfunction

		function void write_reg(logic [REG_IDX_W-1:0] idx, logic [W-1:0] val);
			if (idx == REG_EXPONENT) begin
				exponent_val = val;
			end else if (idx == REG_MODULUS) begin
				modulus_val = (val < MIN_MODULUS) ? W'(MIN_MODULUS) : val;
			end
		endfunction

		// Right-to-left square and multiply; extra rounds past the top set bit
		// leave the accumulator alone.
		function logic [W-1:0] raise_mod(logic [W-1:0] base);
			longint unsigned acc;
			longint unsigned sq;
			longint unsigned n;
			logic [W-1:0] bits;
			acc = 1;
			sq = base;
			n = modulus_val;
			bits = exponent_val;
			for (int r = 0; r < W; r++) begin
				if (bits[0]) begin
					acc = (acc * sq) % n;
				end
				bits = bits >> 1;
				sq = (sq * sq) % n;
			end
			return W'(acc);
		endfunction

		function void note_message(logic [W-1:0] msg);
			expected_powers.push_back(raise_mod(msg));
		endfunction

		function void check_power(logic [W-1:0] got);
			logic [W-1:0] want;
			if (expected_powers.size() == 0) begin
				$display("%0t: power_mod %h arrived with no message outstanding", $time, got);
				errors++;
			end else begin
				want = expected_powers.pop_front();
				if (got !== want) begin
					$display("%0t: power_mod expected %h, actual %h", $time, want, got);
					errors++;
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic [W-1:0] message;
	logic done;
	logic [W-1:0] power_mod;
	logic wr_en;
	logic [REG_IDX_W-1:0] wr_index;
	logic [W-1:0] wr_data;

	powmod_tracker sb = new();
	int idle_cycles = 0;

	modular_exponentiation #(.WIDTH(W)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.message(message),
		.done(done),
		.power_mod(power_mod),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Beats are noted and results checked at the rising edge; the watchdog
	// restarts whenever either side moves a beat.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				sb.note_message(message);
			end
			if (done) begin
				sb.check_power(power_mod);
			end
			if ((start && !busy) || done) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
				$display("modular_exponentiation: mismatch");
				$finish;
			end
		end
	end

	task automatic set_reg(logic [REG_IDX_W-1:0] idx, logic [W-1:0] val);
		wr_en = 1'b1;
		wr_index = idx;
		wr_data = val;
		sb.write_reg(idx, val);
		@(negedge clk);
		wr_en = 1'b0;
	endtask

	task automatic wait_idle();
		start = 1'b0;
		while (sb.expected_powers.size() != 0 || busy) begin
			@(negedge clk);
		end
	endtask

	task automatic apply_setting(logic [W-1:0] expo, logic [W-1:0] modv);
		wait_idle();
		set_reg(REG_EXPONENT, expo);
		set_reg(REG_MODULUS, modv);
	endtask

	// Start stays high across back-to-back beats; it only drops for a gap.
	task automatic send_message(logic [W-1:0] msg, int gap);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start = 1'b1;
		message = msg;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	initial begin
		logic [W-1:0] exp_pick;
		logic [W-1:0] mod_pick;
		logic [W-1:0] msg_pick;
		bit no_idle;
		arst_n = 1'b0;
		start = 1'b0;
		message = '0;
		wr_en = 1'b0;
		wr_index = REG_EXPONENT;
		wr_data = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// Reset values: exponent zero gives 1 for any message.
		send_message('0, $urandom_range(0, 8));
		send_message('1, $urandom_range(0, 8));

		apply_setting('1, '1);
		send_message('0, $urandom_range(0, 8));
		send_message(W'(1), $urandom_range(0, 8));
		send_message('1, $urandom_range(0, 8));
		send_message(W'(16'hFFFE), $urandom_range(0, 8));
		send_message(W'(16'h8000), $urandom_range(0, 8));

		// Moduli of 0 and 1 saturate to 2.
		apply_setting(W'(3), '0);
		send_message('0, $urandom_range(0, 8));
		send_message(W'(1), $urandom_range(0, 8));
		send_message(W'(2), $urandom_range(0, 8));
		send_message('1, $urandom_range(0, 8));
		apply_setting(W'(16'h8000), W'(1));
		send_message(W'(5), $urandom_range(0, 8));
		send_message('1, $urandom_range(0, 8));

		// Messages below, at and above the modulus.
		apply_setting(W'(1), W'(16'h8000));
		send_message(W'(16'h8000), $urandom_range(0, 8));
		send_message('1, $urandom_range(0, 8));
		send_message(W'(16'h7FFF), $urandom_range(0, 8));
		apply_setting(W'(2), W'(16'h8000));
		send_message('1, $urandom_range(0, 8));

		// Small RSA key pair: encrypt with e = 17, then decrypt with d = 2753.
		apply_setting(W'(17), W'(3233));
		send_message(W'(65), $urandom_range(0, 8));
		send_message(W'(123), $urandom_range(0, 8));
		apply_setting(W'(2753), W'(3233));
		send_message(W'(2790), $urandom_range(0, 8));
		send_message(W'(855), $urandom_range(0, 8));

		for (int p = 0; p < PHASES; p++) begin
			case ($urandom_range(0, 5))
				0: exp_pick = '0;
				1: exp_pick = '1;
				2: exp_pick = W'($urandom_range(0, 15));
				default: exp_pick = W'($urandom);
			endcase
			case ($urandom_range(0, 5))
				0: mod_pick = W'($urandom_range(0, 3));
				1: mod_pick = '1;
				2: mod_pick = W'($urandom_range(2, 255));
				default: mod_pick = W'($urandom);
			endcase
			apply_setting(exp_pick, mod_pick);
			no_idle = (p % 4 == 1);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				case ($urandom_range(0, 7))
					0: msg_pick = '0;
					1: msg_pick = '1;
					2: msg_pick = W'($urandom_range(0, 3));
					3: msg_pick = sb.modulus_val - W'($urandom_range(0, 1));
					default: msg_pick = W'($urandom);
				endcase
				send_message(msg_pick, no_idle ? 0 : $urandom_range(0, 8));
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.errors == 0) begin
			$display("modular_exponentiation: match");
		end else begin
			$display("modular_exponentiation: mismatch");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/mexp_pkg.sv
rtl/mexp_modmul.sv
rtl/modular_exponentiation.sv
rtl/mexp_chk.sv
sim/tb_modular_exponentiation.sv
